FILE: src/pett_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pett_pkg
// Shared constants and codes for the periodic event timer table.
// ----------------------------------------------------------------------------
package pett_pkg;

   // Default sizes
   localparam int TIMER_SLOTS_DEF = 16;
   localparam int TIME_WIDTH_DEF  = 32;
   localparam int EVENT_WIDTH_DEF = 16;

   // Request codes
   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FIRED = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

FILE: src/pett_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pett_if
// Valid/ready channels for timer requests and timer results.
// ----------------------------------------------------------------------------
interface pett_req_if #(
   parameter int TW = pett_pkg::TIME_WIDTH_DEF,
   parameter int EW = pett_pkg::EVENT_WIDTH_DEF
);
   logic          valid;
   logic          ready;
   logic [1:0]    req_type;
   logic [TW-1:0] period;
   logic [EW-1:0] event_id;
   logic          repeat_req;
   logic [TW-1:0] elapsed;

   modport source (output valid, req_type, period, event_id, repeat_req, elapsed,
                   input ready);
   modport sink   (input valid, req_type, period, event_id, repeat_req, elapsed,
                   output ready);
endinterface

interface pett_rsp_if #(
   parameter int EW = pett_pkg::EVENT_WIDTH_DEF
);
   logic          valid;
   logic          ready;
   logic [1:0]    status;
   logic [EW-1:0] fired_event;
   logic          last;

   modport source (output valid, status, fired_event, last, input ready);
   modport sink   (input valid, status, fired_event, last, output ready);
endinterface

FILE: src/pett_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pett_slot_ram
// Timer slot store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pett_slot_ram #(
   parameter int DEPTH = pett_pkg::TIMER_SLOTS_DEF,
   parameter int WIDTH = 2 * pett_pkg::TIME_WIDTH_DEF + pett_pkg::EVENT_WIDTH_DEF + 1,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pett_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pett_alu
// Saturating countdown step: subtract elapsed time, flag expiry at zero.
// ----------------------------------------------------------------------------
module pett_alu #(
   parameter int TW = pett_pkg::TIME_WIDTH_DEF
) (
   input  logic [TW-1:0] remaining,
   input  logic [TW-1:0] elapsed,
   output logic [TW-1:0] remaining_next,
   output logic          fired
);

   logic still_running;

   assign still_running  = remaining > elapsed;
   assign remaining_next = still_running ? (remaining - elapsed) : '0;
   assign fired          = !still_running;

endmodule

FILE: src/periodic_event_timer_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_event_timer_table_top
// Ordered table of countdown timers with add, tick and clear requests.
//
//   channel   dir   word contents
//   req_port  in    req_type, period, event_id, repeat_req, elapsed
//   rsp_port  out   status, fired_event, last
//
// Add, clear and unknown requests each give a single result word.
// A tick walks the table through one shared subtract/compare unit and the
// slot memory: each stored timer is read, then updated, and a final step
// delivers the last word; the read has its own step as read data is registered.
// Reset clears the timer count; the slot memory needs no clearing.
// Back-pressure on rsp_port stalls the walk in the update step when a second
// timer fires, and in the final step; a waiting word holds req_port off.
// ----------------------------------------------------------------------------
module periodic_event_timer_table_top #(
   parameter int TIMER_SLOTS = pett_pkg::TIMER_SLOTS_DEF,
   parameter int TIME_WIDTH  = pett_pkg::TIME_WIDTH_DEF,
   parameter int EVENT_WIDTH = pett_pkg::EVENT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pett_req_if.sink    req_port,
   pett_rsp_if.source  rsp_port
);

   localparam int CW   = $clog2(TIMER_SLOTS + 1);
   localparam int IW   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int TW   = TIME_WIDTH;
   localparam int EW   = EVENT_WIDTH;
   localparam int EN_W = 2 * TW + EW + 1;

   // Slot word layout: {period, remaining, event, repeat}
   localparam int REP_LO = 0;
   localparam int EV_LO  = 1;
   localparam int REM_LO = EW + 1;
   localparam int PER_LO = TW + EW + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CALC,
      S_FLUSH
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic [TW-1:0] elapsed_ff, elapsed_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [EW-1:0] pend_event_ff, pend_event_in;
   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_status_ff, out_status_in;
   logic [EW-1:0] out_event_ff, out_event_in;
   logic          out_last_ff, out_last_in;

   logic            req_fire;
   logic            out_free;
   logic            push;
   logic [1:0]      push_status;
   logic [EW-1:0]   push_event;
   logic            push_last;

   logic            ram_we;
   logic [IW-1:0]   ram_waddr;
   logic [EN_W-1:0] ram_wdata;
   logic            ram_re;
   logic [EN_W-1:0] ram_rdata;

   logic [TW-1:0]   slot_period;
   logic [TW-1:0]   slot_remaining;
   logic [EW-1:0]   slot_event;
   logic            slot_repeat;
   logic [TW-1:0]   alu_remaining;
   logic            alu_fired;

   // Slot store and the shared countdown unit
   pett_slot_ram #(
      .DEPTH (TIMER_SLOTS),
      .WIDTH (EN_W),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   assign slot_period    = ram_rdata[PER_LO +: TW];
   assign slot_remaining = ram_rdata[REM_LO +: TW];
   assign slot_event     = ram_rdata[EV_LO  +: EW];
   assign slot_repeat    = ram_rdata[REP_LO];

   pett_alu #(
      .TW (TW)
   ) u_alu (
      .remaining      (slot_remaining),
      .elapsed        (elapsed_ff),
      .remaining_next (alu_remaining),
      .fired          (alu_fired)
   );

   // Output register is free when empty or being drained this cycle
   assign out_free       = !out_valid_ff || rsp_port.ready;
   assign req_port.ready = (state_ff == S_IDLE) && out_free;
   assign req_fire       = req_port.valid && req_port.ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      elapsed_in    = elapsed_ff;
      pend_valid_in = pend_valid_ff;
      pend_event_in = pend_event_ff;
      push          = 1'b0;
      push_status   = pett_pkg::ST_DONE;
      push_event    = '0;
      push_last     = 1'b1;
      ram_we        = 1'b0;
      ram_waddr     = wr_idx_ff[IW-1:0];
      ram_wdata     = {slot_period, alu_remaining, slot_event, slot_repeat};
      ram_re        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_port.req_type)
                  pett_pkg::REQ_ADD: begin
                     push = 1'b1;
                     if (count_ff >= CW'(TIMER_SLOTS)) begin
                        // table full: drop the add
                        push_status = pett_pkg::ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[IW-1:0];
                        ram_wdata = {req_port.period, req_port.period,
                                     req_port.event_id, req_port.repeat_req};
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  pett_pkg::REQ_TICK: begin
                     // start the walk from slot zero
                     elapsed_in    = req_port.elapsed;
                     rd_idx_in     = '0;
                     wr_idx_in     = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_READ;
                  end
                  pett_pkg::REQ_CLEAR: begin
                     push     = 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     push = 1'b1;
                  end
               endcase
            end
         end

         S_READ: begin
            if (rd_idx_ff == count_ff) begin
               state_in = S_FLUSH;
            end else begin
               ram_re   = 1'b1;
               state_in = S_CALC;
            end
         end

         S_CALC: begin
            // a second firing has to push the held one out first
            if (!(alu_fired && pend_valid_ff && !out_free)) begin
               if (!alu_fired || slot_repeat) begin
                  // keep the timer, compacted down to the write slot
                  ram_we = 1'b1;
                  if (alu_fired) begin
                     ram_wdata = {slot_period, slot_period, slot_event, slot_repeat};
                  end
                  wr_idx_in = wr_idx_ff + CW'(1);
               end
               if (alu_fired) begin
                  if (pend_valid_ff) begin
                     push        = 1'b1;
                     push_status = pett_pkg::ST_FIRED;
                     push_event  = pend_event_ff;
                     push_last   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_event_in = slot_event;
               end
               rd_idx_in = rd_idx_ff + CW'(1);
               state_in  = S_READ;
            end
         end

         S_FLUSH: begin
            // deliver the final word and commit the compacted count
            if (out_free) begin
               push = 1'b1;
               if (pend_valid_ff) begin
                  push_status = pett_pkg::ST_FIRED;
                  push_event  = pend_event_ff;
               end
               count_in      = wr_idx_ff;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_valid_in  = out_valid_ff && !rsp_port.ready;
      out_status_in = out_status_ff;
      out_event_in  = out_event_ff;
      out_last_in   = out_last_ff;
      if (push) begin
         out_valid_in  = 1'b1;
         out_status_in = push_status;
         out_event_in  = push_event;
         out_last_in   = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         wr_idx_ff     <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_idx_ff     <= rd_idx_in;
         wr_idx_ff     <= wr_idx_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      elapsed_ff    <= elapsed_in;
      pend_event_ff <= pend_event_in;
      out_status_ff <= out_status_in;
      out_event_ff  <= out_event_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.status      = out_status_ff;
   assign rsp_port.fired_event = out_event_ff;
   assign rsp_port.last        = out_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TIMER_SLOTS))
      else $error("timer count above table size");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (wr_idx_ff <= rd_idx_ff))
      else $error("write slot ahead of read slot during walk");

   a_calc_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC) |-> (rd_idx_ff < count_ff))
      else $error("update step outside stored timers");

   a_nonfinal_in_walk: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> (state_ff != S_IDLE))
      else $error("non-final word while idle");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_status_ff == pett_pkg::ST_FULL))
         |-> (count_ff == CW'(TIMER_SLOTS)))
      else $error("full status with room in table");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic event timer table.
//
// Words go in on the request channel and come out on the result channel. A
// model of the timer table inside the bench predicts the result words of
// every accepted request. The bench then compares each result word, field by
// field, against the oldest prediction. A short directed table runs first. It
// covers the empty table, the zero period, a full table and a tick that fires
// every slot. A long random run follows. Both channels idle at random, one
// long result stall backs the block up, and the bench pauses once for a full
// drain.
// ----------------------------------------------------------------------------
module testbench;

   // ------------------------------------------------------------------------
   // Sizes, codes and run shape
   // ------------------------------------------------------------------------
   localparam int TW    = pett_pkg::TIME_WIDTH_DEF;
   localparam int EW    = pett_pkg::EVENT_WIDTH_DEF;
   localparam int SLOTS = pett_pkg::TIMER_SLOTS_DEF;

   // Request code that the block must ignore (answers with a plain done word)
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   localparam int RANDOM_WORDS     = 440;   // counted request words after the table
   localparam int LONG_HOLD_AT     = 120;   // random word that triggers the long stall
   localparam int DRAIN_PAUSE_AT   = 300;   // random word after which the sender drains
   localparam int CALM_FROM        = 380;   // no idling on either side from here on
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 4 * SLOTS + 16;  // a full walk, with slack
   localparam int CYCLE_LIMIT      = 400_000;
   localparam int PRINT_CAP        = 40;

   typedef struct packed {
      logic [1:0]    kind;
      logic [TW-1:0] period;
      logic [EW-1:0] event_id;
      logic          repeat_req;
      logic [TW-1:0] elapsed;
   } timer_word_type;

   typedef struct packed {
      logic [1:0]    status;
      logic [EW-1:0] fired_event;
      logic          last;
   } timer_result_type;

   // One row of the directed table. A row with several repeats adds a run of
   // timers: period scales with the repeat index, event counts up, and the
   // reload flag alternates.
   typedef struct packed {
      timer_word_type   word;
      logic [4:0]       repeats;
      logic             typed;        // result is typed in below, not predicted
      timer_result_type typed_result;
   } stim_row_type;

   // ------------------------------------------------------------------------
   // Clock, reset, channels and the block
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   pett_req_if #(.TW(TW), .EW(EW)) req_if ();
   pett_rsp_if #(.EW(EW))          rsp_if ();

   periodic_event_timer_table_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   timer_result_type due_results[$];   // result words the block still owes
   timer_result_type step_results[$];  // result words of the request just modeled

   // Shadow of the timer table
   logic [TW-1:0] shadow_period [SLOTS];
   logic [TW-1:0] shadow_left   [SLOTS];
   logic [EW-1:0] shadow_event  [SLOTS];
   logic          shadow_reload [SLOTS];
   int unsigned   shadow_count = 0;

   // Side band that travels with the request word: a typed-in expectation
   logic             word_typed = 1'b0;
   timer_result_type word_typed_result = '0;

   int unsigned error_count        = 0;
   int unsigned cycle_count        = 0;
   int unsigned sender_quiet_words = 0;
   bit          calm               = 1'b0;
   bit          long_hold_pending  = 1'b0;

   // Append one predicted word to the results of the current request
   function automatic void add_step_result(input logic [1:0] status,
                                           input logic [EW-1:0] ev,
                                           input logic last);
      timer_result_type r;
      r.status      = status;
      r.fired_event = ev;
      r.last        = last;
      step_results.insert(step_results.size(), r);
   endfunction

   // ------------------------------------------------------------------------
   // Timer table model: apply one request word, leave its results in
   // step_results
   // ------------------------------------------------------------------------
   function automatic void advance_timer_table(input timer_word_type w);
      int unsigned   i;
      int unsigned   j;
      logic [TW-1:0] left;
      step_results.delete();
      case (w.kind)
         pett_pkg::REQ_ADD: begin
            if (shadow_count >= SLOTS) begin
               add_step_result(pett_pkg::ST_FULL, '0, 1'b1);
            end else begin
               shadow_period[shadow_count] = w.period;
               shadow_left[shadow_count]   = w.period;
               shadow_event[shadow_count]  = w.event_id;
               shadow_reload[shadow_count] = w.repeat_req;
               shadow_count++;
               add_step_result(pett_pkg::ST_DONE, '0, 1'b1);
            end
         end
         pett_pkg::REQ_TICK: begin
            i = 0;
            while (i < shadow_count) begin
               // Count down, saturating at zero
               left = (shadow_left[i] > w.elapsed) ? shadow_left[i] - w.elapsed : '0;
               shadow_left[i] = left;
               if (left == '0) begin
                  add_step_result(pett_pkg::ST_FIRED, shadow_event[i], 1'b0);
                  if (shadow_reload[i]) begin
                     shadow_left[i] = shadow_period[i];
                     i++;
                  end else begin
                     // Drop a one-shot and close the gap, keeping order
                     for (j = i; j + 1 < shadow_count; j++) begin
                        shadow_period[j] = shadow_period[j + 1];
                        shadow_left[j]   = shadow_left[j + 1];
                        shadow_event[j]  = shadow_event[j + 1];
                        shadow_reload[j] = shadow_reload[j + 1];
                     end
                     shadow_count--;
                  end
               end else begin
                  i++;
               end
            end
            if (step_results.size() == 0)
               add_step_result(pett_pkg::ST_DONE, '0, 1'b1);
            else
               step_results[step_results.size() - 1].last = 1'b1;
         end
         pett_pkg::REQ_CLEAR: begin
            shadow_count = 0;
            add_step_result(pett_pkg::ST_DONE, '0, 1'b1);
         end
         default: begin
            add_step_result(pett_pkg::ST_DONE, '0, 1'b1);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Mismatch report: one line, counted; print only the first few
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // Monitor: model accepted requests first, then check the accepted result,
   // all on the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      timer_word_type   taken;
      timer_result_type seen;
      timer_result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            taken = {req_if.req_type, req_if.period, req_if.event_id,
                     req_if.repeat_req, req_if.elapsed};
            advance_timer_table(taken);
            // A typed-in result replaces the model's answer for this word
            if (word_typed)
               due_results.insert(due_results.size(), word_typed_result);
            else
               foreach (step_results[k])
                  due_results.insert(due_results.size(), step_results[k]);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen = {rsp_if.status, rsp_if.fired_event, rsp_if.last};
            if (due_results.size() == 0) begin
               report_mismatch("result word with nothing due", 32'(seen), '0);
            end else begin
               want = due_results.pop_front();
               if (seen.status !== want.status)
                  report_mismatch("status", 32'(seen.status), 32'(want.status));
               if (seen.fired_event !== want.fired_event)
                  report_mismatch("fired_event", 32'(seen.fired_event),
                                  32'(want.fired_event));
               if (seen.last !== want.last)
                  report_mismatch("last", 32'(seen.last), 32'(want.last));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run if it hangs
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Result side: random stalls, one long hold on request, none when calm.
   // Each pass assigns ready once and then holds it over a span of falling edges.
   // ------------------------------------------------------------------------
   initial begin : result_ready_driver
      int unsigned span;
      rsp_if.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_pending) begin
            // Hold off long enough for the block to fill and stall its input
            long_hold_pending = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            span = $urandom_range(1, 7);
            repeat (span) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            span = $urandom_range(1, 24);
            repeat (span) @(negedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one word from a falling edge, hold it until accepted, and return
   // on the next falling edge with valid still high.
   task automatic offer_word(input timer_word_type w, input logic typed,
                             input timer_result_type typed_res);
      req_if.valid      <= 1'b1;
      req_if.req_type   <= w.kind;
      req_if.period     <= w.period;
      req_if.event_id   <= w.event_id;
      req_if.repeat_req <= w.repeat_req;
      req_if.elapsed    <= w.elapsed;
      word_typed        <= typed;
      word_typed_result <= typed_res;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid for a random burst now and then, with runs of back-to-back
   // words in between.
   task automatic maybe_idle_sender();
      int unsigned span;
      if (!calm) begin
         if (sender_quiet_words != 0) begin
            sender_quiet_words--;
         end else if ($urandom_range(0, 2) == 0) begin
            req_if.valid <= 1'b0;
            span = $urandom_range(1, 7);
            repeat (span) @(negedge clock);
            sender_quiet_words = $urandom_range(0, 12);
         end
      end
   endtask

   // Random request word. Periods lean small so that timers fire often, with
   // zero, all-ones and full-range values mixed in. Fields that a request
   // does not use still get random values.
   function automatic timer_word_type random_timer_word();
      timer_word_type w;
      int unsigned    pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         w.kind = pett_pkg::REQ_ADD;
      else if (pick < 88)
         w.kind = pett_pkg::REQ_TICK;
      else if (pick < 95)
         w.kind = pett_pkg::REQ_CLEAR;
      else
         w.kind = REQ_UNKNOWN;
      case ($urandom_range(0, 9))
         0:       w.period = '0;
         1:       w.period = '1;
         2, 3:    w.period = TW'($urandom);
         default: w.period = TW'($urandom_range(1, 32'h0004_0000));
      endcase
      case ($urandom_range(0, 9))
         0:       w.elapsed = '0;
         1:       w.elapsed = '1;
         2:       w.elapsed = TW'($urandom);
         default: w.elapsed = TW'($urandom_range(0, 32'h0002_0000));
      endcase
      w.event_id   = EW'($urandom);
      w.repeat_req = 1'($urandom_range(0, 1));
      return w;
   endfunction

   initial begin : stimulus
      stim_row_type   directed[$];
      stim_row_type   row;
      timer_word_type w;
      int unsigned    done_words;

      req_if.valid      = 1'b0;
      req_if.req_type   = pett_pkg::REQ_ADD;
      req_if.period     = '0;
      req_if.event_id   = '0;
      req_if.repeat_req = 1'b0;
      req_if.elapsed    = '0;

      // Directed table: word (type, period, event, reload, elapsed), repeats,
      // typed flag, typed result
      // Tick on an empty table
      directed.insert(directed.size(), stim_row_type'{
         '{pett_pkg::REQ_TICK, 32'h0, 16'h0, 1'b0, 32'h0}, 5'd1, 1'b1,
         '{pett_pkg::ST_DONE, 16'h0, 1'b1}});
      // Clear an empty table
      directed.insert(directed.size(), stim_row_type'{
         '{pett_pkg::REQ_CLEAR, 32'h0, 16'h0, 1'b0, 32'h0}, 5'd1, 1'b1,
         '{pett_pkg::ST_DONE, 16'h0, 1'b1}});
      // Unknown request with every field at all ones
      directed.insert(directed.size(), stim_row_type'{
         '{REQ_UNKNOWN, '1, '1, 1'b1, '1}, 5'd1, 1'b1,
         '{pett_pkg::ST_DONE, 16'h0, 1'b1}});
      // Zero-period reloading timer with the top event number
      directed.insert(directed.size(), stim_row_type'{
         '{pett_pkg::REQ_ADD, 32'h0, 16'hFFFF, 1'b1, 32'h0}, 5'd1, 1'b1,
         '{pett_pkg::ST_DONE, 16'h0, 1'b1}});
      // It fires even on a tick of zero elapsed time, and stays
      directed.insert(directed.size(), stim_row_type'{
         '{pett_pkg::REQ_TICK, 32'h0, 16'h0, 1'b0, 32'h0}, 5'd1, 1'b1,
         '{pett_pkg::ST_FIRED, 16'hFFFF, 1'b1}});
      // Fill the table: periods of 1 to 15 seconds, alternating reload
      directed.insert(directed.size(), stim_row_type'{
         '{pett_pkg::REQ_ADD, 32'h0001_0000, 16'h0100, 1'b0, 32'h0}, 5'd15, 1'b1,
         '{pett_pkg::ST_DONE, 16'h0, 1'b1}});
      // Add to a full table
      directed.insert(directed.size(), stim_row_type'{
         '{pett_pkg::REQ_ADD, 32'h1234_5678, 16'hBEEF, 1'b1, 32'h0}, 5'd1, 1'b1,
         '{pett_pkg::ST_FULL, 16'h0, 1'b1}});
      // Five seconds: fire a mix, drop the one-shots from the middle
      directed.insert(directed.size(), stim_row_type'{
         '{pett_pkg::REQ_TICK, 32'h0, 16'h0, 1'b0, 32'h0005_0000}, 5'd1, 1'b0,
         '{pett_pkg::ST_DONE, 16'h0, 1'b1}});
      // Refill with the longest periods
      directed.insert(directed.size(), stim_row_type'{
         '{pett_pkg::REQ_ADD, 32'hFFFF_FFFF, 16'hFF00, 1'b0, 32'h0}, 5'd3, 1'b1,
         '{pett_pkg::ST_DONE, 16'h0, 1'b1}});
      // Longest tick: every slot fires
      directed.insert(directed.size(), stim_row_type'{
         '{pett_pkg::REQ_TICK, 32'h0, 16'h0, 1'b0, 32'hFFFF_FFFF}, 5'd1, 1'b0,
         '{pett_pkg::ST_DONE, 16'h0, 1'b1}});
      directed.insert(directed.size(), stim_row_type'{
         '{pett_pkg::REQ_CLEAR, 32'h0, 16'h0, 1'b0, 32'h0}, 5'd1, 1'b1,
         '{pett_pkg::ST_DONE, 16'h0, 1'b1}});

      // Hold reset from the start, release on a falling edge
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      foreach (directed[r]) begin
         row = directed[r];
         for (int k = 0; k < row.repeats; k++) begin
            w = row.word;
            if (row.repeats > 1) begin
               w.period     = TW'(row.word.period * (k + 1));
               w.event_id   = EW'(row.word.event_id + k);
               w.repeat_req = k[0];
            end
            maybe_idle_sender();
            offer_word(w, row.typed, row.typed_result);
         end
      end

      // Random run; ignored request codes do not count
      done_words = 0;
      while (done_words < RANDOM_WORDS) begin
         if (done_words == LONG_HOLD_AT)
            long_hold_pending = 1'b1;
         if (done_words >= CALM_FROM)
            calm = 1'b1;
         maybe_idle_sender();
         w = random_timer_word();
         offer_word(w, 1'b0, '0);
         if (w.kind != REQ_UNKNOWN)
            done_words++;
         if (done_words == DRAIN_PAUSE_AT && w.kind != REQ_UNKNOWN) begin
            // Pause until the block owes nothing
            req_if.valid <= 1'b0;
            while (due_results.size() != 0) @(negedge clock);
         end
      end

      // Drain, then give the block time to show any stray words
      req_if.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && due_results.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
